// ===== rtl/ypcb_pkg.sv =====
// shared types and constants for the yaw/pitch camera basis block
`timescale 1ns / 1ps

package ypcb_pkg;

  localparam int unsigned FULL_TURN    = 92160;
  localparam int unsigned QUARTER_TURN = 23040;
  localparam int unsigned EIGHTH_TURN  = 11520;
  localparam int          PITCH_LIMIT  = 22784;

  typedef struct packed {
    logic signed [15:0] pitch;
    logic [16:0]        yaw;
  } angle_t;

  typedef struct packed {
    logic [11:0] sensitivity;
    logic        invert_pitch;
  } front_cfg_t;

  typedef struct packed {
    logic               left_handed;
    logic signed [15:0] world_up_x;
    logic signed [15:0] world_up_y;
    logic signed [15:0] world_up_z;
  } basis_cfg_t;

  typedef struct packed {
    logic signed [15:0] forward_x;
    logic signed [15:0] forward_y;
    logic signed [15:0] forward_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } result_t;

endpackage

// ===== rtl/ypcb_front.sv =====
// front end: scales steps, accumulates and clamps pitch, wraps yaw
`timescale 1ns / 1ps

module ypcb_front (
  input  logic                  clk,
  input  logic                  rst,
  input  ypcb_pkg::front_cfg_t  cfg,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [11:0]    pitch_step,
  input  logic signed [11:0]    yaw_step,
  output logic                  push,
  output ypcb_pkg::angle_t      push_data,
  input  logic                  q_full
);
  import ypcb_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_CALC, F_RED, F_PUSH} state_t;

  state_t             state;
  logic signed [15:0] pitch;
  logic [16:0]        yaw;
  logic signed [24:0] dp;
  logic signed [24:0] dy;
  logic [23:0]        mag;
  logic               vneg;
  logic [2:0]         k;

  logic signed [24:0] dp_c;
  logic signed [24:0] dy_c;
  logic signed [25:0] psum;
  logic signed [15:0] pitch_next;
  logic signed [25:0] ysum;
  logic [23:0]        sub;
  logic [16:0]        yaw_next;

  assign dp_c = 25'(pitch_step) * 25'(signed'({1'b0, cfg.sensitivity}));
  assign dy_c = 25'(yaw_step) * 25'(signed'({1'b0, cfg.sensitivity}));

  always_comb begin
    psum = 26'(pitch) + 26'(dp);
    if (psum > 26'(PITCH_LIMIT)) begin
      pitch_next = 16'(PITCH_LIMIT);
    end else if (psum < -26'(PITCH_LIMIT)) begin
      pitch_next = -16'(PITCH_LIMIT);
    end else begin
      pitch_next = 16'(psum);
    end
    ysum = signed'(26'(yaw)) + 26'(dy);
    sub = 24'(FULL_TURN) << k;
    yaw_next = (vneg && (mag != 24'd0)) ? 17'(24'(FULL_TURN) - mag) : 17'(mag);
  end

  assign in_stall  = (state != F_IDLE);
  assign push      = (state == F_PUSH) && !q_full;
  assign push_data = '{pitch: pitch, yaw: yaw_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      pitch <= '0;
      yaw   <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            dp    <= cfg.invert_pitch ? -dp_c : dp_c;
            dy    <= dy_c;
            state <= F_CALC;
          end
        end
        F_CALC: begin
          pitch <= pitch_next;
          vneg  <= ysum < 0;
          mag   <= (ysum < 0) ? 24'(-ysum) : 24'(ysum);
          k     <= 3'd6;
          state <= F_RED;
        end
        F_RED: begin
          if (mag >= sub) begin
            mag <= mag - sub;
          end
          if (k == 3'd0) begin
            state <= F_PUSH;
          end else begin
            k <= k - 3'd1;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            yaw   <= yaw_next;
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/ypcb_queue.sv =====
// two-entry queue of angle pairs between front and back
`timescale 1ns / 1ps

module ypcb_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ypcb_pkg::angle_t push_data,
  output logic             full,
  output logic             valid,
  output ypcb_pkg::angle_t pop_data,
  input  logic             pop
);
  import ypcb_pkg::*;

  angle_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/ypcb_back.sv =====
// back end: sequenced sine/cosine series, forward vector and cross products
`timescale 1ns / 1ps

module ypcb_back #(
  parameter int VECTOR_FRACTION_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ypcb_pkg::basis_cfg_t cfg,
  input  logic                 q_valid,
  input  ypcb_pkg::angle_t     q_data,
  output logic                 q_pop,
  output logic                 res_valid,
  input  logic                 res_ready,
  output ypcb_pkg::result_t    res
);
  import ypcb_pkg::*;

  localparam int    FwdShift = 60 - VECTOR_FRACTION_BITS;
  localparam int    FyShift  = 30 - VECTOR_FRACTION_BITS;
  localparam int    UpShl    = (VECTOR_FRACTION_BITS >= 14) ? VECTOR_FRACTION_BITS - 14 : 0;
  localparam int    UpShr    = (VECTOR_FRACTION_BITS < 14) ? 14 - VECTOR_FRACTION_BITS : 0;
  localparam longint PiQ34   = 64'd53972150818;
  localparam longint XConstA = PiQ34 / 737280;
  localparam longint XConstB = PiQ34 % 737280;
  localparam longint Recip45 = (64'd1 << 20) / 45;
  localparam logic signed [67:0] Half = 68'sd536870912;
  localparam logic [30:0] Q30One = 31'h4000_0000;

  typedef enum logic [4:0] {
    B_IDLE, B_ANG, B_XB, B_XDIV, B_XCOR, B_XSQ, B_X2,
    B_H1, B_H2, B_H3, B_H4, B_FS, B_FS2,
    B_F1, B_F2, B_F3, B_CA, B_CB, B_CC, B_OUT
  } state_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } vec_t;

  function automatic logic signed [67:0] rnd(input logic signed [67:0] v, input int sh);
    logic [67:0] mag;
    logic [67:0] r;
    mag = v[67] ? 68'(-v) : 68'(v);
    if (sh == 0) begin
      r = mag;
    end else begin
      r = (mag + (68'd1 << ((sh > 0) ? sh - 1 : 0))) >> sh;
    end
    return v[67] ? -signed'(r) : signed'(r);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [67:0] v);
    if (v > 68'sd32767) begin
      return 16'sh7fff;
    end else if (v < -68'sd32768) begin
      return -16'sh8000;
    end
    return 16'(v);
  endfunction

  function automatic logic [7:0] hdiv(input logic sin_sel, input logic [2:0] k);
    case ({sin_sel, k})
      4'b1111: return 8'd210;
      4'b1110: return 8'd156;
      4'b1101: return 8'd110;
      4'b1100: return 8'd72;
      4'b1011: return 8'd42;
      4'b1010: return 8'd20;
      4'b1001: return 8'd6;
      4'b0111: return 8'd182;
      4'b0110: return 8'd132;
      4'b0101: return 8'd90;
      4'b0100: return 8'd56;
      4'b0011: return 8'd30;
      4'b0010: return 8'd12;
      4'b0001: return 8'd2;
      default: return 8'd1;
    endcase
  endfunction

  function automatic logic [30:0] hrecip(input logic sin_sel, input logic [2:0] k);
    case ({sin_sel, k})
      4'b1111: return 31'(33'h0_8000_0000 / 33'd210);
      4'b1110: return 31'(33'h0_8000_0000 / 33'd156);
      4'b1101: return 31'(33'h0_8000_0000 / 33'd110);
      4'b1100: return 31'(33'h0_8000_0000 / 33'd72);
      4'b1011: return 31'(33'h0_8000_0000 / 33'd42);
      4'b1010: return 31'(33'h0_8000_0000 / 33'd20);
      4'b1001: return 31'(33'h0_8000_0000 / 33'd6);
      4'b0111: return 31'(33'h0_8000_0000 / 33'd182);
      4'b0110: return 31'(33'h0_8000_0000 / 33'd132);
      4'b0101: return 31'(33'h0_8000_0000 / 33'd90);
      4'b0100: return 31'(33'h0_8000_0000 / 33'd56);
      4'b0011: return 31'(33'h0_8000_0000 / 33'd30);
      4'b0010: return 31'(33'h0_8000_0000 / 33'd12);
      4'b0001: return 31'(33'h0_8000_0000 / 33'd2);
      default: return 31'd0;
    endcase
  endfunction

  function automatic logic signed [33:0] conv_up(input logic signed [15:0] w);
    if (VECTOR_FRACTION_BITS >= 14) begin
      return 34'(w) <<< UpShl;
    end
    return 34'(rnd(68'(w), UpShr));
  endfunction

  state_t             state;
  logic signed [67:0] prod;
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic               ai;
  logic signed [15:0] ang_p;
  logic [16:0]        ang_y;
  logic [1:0]         quad;
  logic               swap;
  logic [13:0]        rr;
  logic [29:0]        xa;
  logic [19:0]        mh;
  logic [29:0]        x;
  logic [29:0]        x2;
  logic [30:0]        ts;
  logic [30:0]        tc;
  logic [2:0]         hk;
  logic               hsin;
  logic [30:0]        hn;
  logic [30:0]        hq0;
  logic signed [31:0] sp;
  logic signed [31:0] cp;
  logic signed [31:0] sy;
  logic signed [31:0] cy;
  vec_t               fwd;
  vec_t               rt;
  vec_t               upv;
  logic [1:0]         comp;
  logic               cross_up;
  logic signed [67:0] acc;

  logic signed [17:0] pext;
  logic [16:0]        ang_a;
  logic [1:0]         a_quad;
  logic [14:0]        a_r;
  logic               a_swap;
  logic [13:0]        a_rr;
  logic [19:0]        mh_c;
  logic [19:0]        q45;
  logic [19:0]        rem45;
  logic [29:0]        x_c;
  logic [30:0]        n_c;
  logic [7:0]         hd;
  logic [30:0]        hrem;
  logic [30:0]        hq;
  logic [30:0]        ht;
  logic [30:0]        s_c;
  logic signed [31:0] bs;
  logic signed [31:0] bc;
  logic signed [31:0] sn;
  logic signed [31:0] cs;
  vec_t               wupv;
  vec_t               ca;
  vec_t               cb;
  logic signed [33:0] t1a, t1b, t2a, t2b;
  logic signed [15:0] cross_sat;

  // octant reduction
  always_comb begin
    pext  = 18'(ang_p);
    ang_a = ai ? ang_y : ((ang_p < 0) ? 17'(pext + 18'sd92160) : 17'(pext));
    if (ang_a >= 17'(3 * QUARTER_TURN)) begin
      a_quad = 2'd3;
      a_r    = 15'(ang_a - 17'(3 * QUARTER_TURN));
    end else if (ang_a >= 17'(2 * QUARTER_TURN)) begin
      a_quad = 2'd2;
      a_r    = 15'(ang_a - 17'(2 * QUARTER_TURN));
    end else if (ang_a >= 17'(QUARTER_TURN)) begin
      a_quad = 2'd1;
      a_r    = 15'(ang_a - 17'(QUARTER_TURN));
    end else begin
      a_quad = 2'd0;
      a_r    = 15'(ang_a);
    end
    a_swap = a_r > 15'(EIGHTH_TURN);
    a_rr   = a_swap ? 14'(15'(QUARTER_TURN) - a_r) : 14'(a_r);
  end

  // fixed-point angle to radians and series arithmetic
  always_comb begin
    mh_c  = 20'((prod + 68'sd368640) >>> 14);
    q45   = 20'(prod >>> 20);
    rem45 = mh - 20'(q45 * 20'd45);
    x_c   = 30'(xa + 30'(q45) + 30'(rem45 >= 20'd45));
    n_c   = 31'((prod + Half) >>> 30);
    hd    = hdiv(hsin, hk);
    hrem  = hn - 31'(hq0 * 31'(hd));
    hq    = hq0 + 31'(hrem >= 31'(hd));
    ht    = Q30One - hq;
    s_c   = 31'((prod + Half) >>> 30);
    bs    = swap ? signed'(32'(tc)) : signed'(32'(s_c));
    bc    = swap ? signed'(32'(s_c)) : signed'(32'(tc));
    case (quad)
      2'd0: begin
        sn = bs;
        cs = bc;
      end
      2'd1: begin
        sn = bc;
        cs = -bs;
      end
      2'd2: begin
        sn = -bs;
        cs = -bc;
      end
      default: begin
        sn = -bc;
        cs = bs;
      end
    endcase
  end

  // cross product operands
  always_comb begin
    wupv.x = conv_up(cfg.world_up_x);
    wupv.y = conv_up(cfg.world_up_y);
    wupv.z = conv_up(cfg.world_up_z);
    if (!cross_up) begin
      ca = cfg.left_handed ? wupv : fwd;
      cb = cfg.left_handed ? fwd : wupv;
    end else begin
      ca = cfg.left_handed ? fwd : rt;
      cb = cfg.left_handed ? rt : fwd;
    end
    case (comp)
      2'd0: begin
        t1a = ca.y;
        t1b = cb.z;
        t2a = ca.z;
        t2b = cb.y;
      end
      2'd1: begin
        t1a = ca.z;
        t1b = cb.x;
        t2a = ca.x;
        t2b = cb.z;
      end
      default: begin
        t1a = ca.x;
        t1b = cb.y;
        t2a = ca.y;
        t2b = cb.x;
      end
    endcase
    cross_sat = sat16(rnd(acc - prod, VECTOR_FRACTION_BITS));
  end

  // shared multiplier operands
  always_comb begin
    case (state)
      B_ANG: begin
        mul_a = signed'(34'(a_rr));
        mul_b = 34'(XConstA);
      end
      B_XB: begin
        mul_a = signed'(34'(rr));
        mul_b = 34'(XConstB);
      end
      B_XDIV: begin
        mul_a = signed'(34'(mh_c));
        mul_b = 34'(Recip45);
      end
      B_XSQ: begin
        mul_a = signed'(34'(x));
        mul_b = signed'(34'(x));
      end
      B_H1: begin
        mul_a = signed'(34'(x2));
        mul_b = signed'(34'(hsin ? ts : tc));
      end
      B_H2: begin
        mul_a = signed'(34'(n_c));
        mul_b = signed'(34'(hrecip(hsin, hk)));
      end
      B_FS: begin
        mul_a = signed'(34'(x));
        mul_b = signed'(34'(ts));
      end
      B_F1: begin
        mul_a = 34'(sy);
        mul_b = 34'(cp);
      end
      B_F2: begin
        mul_a = 34'(cy);
        mul_b = 34'(cp);
      end
      B_CA: begin
        mul_a = t1a;
        mul_b = t1b;
      end
      B_CB: begin
        mul_a = t2a;
        mul_b = t2b;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign q_pop     = (state == B_IDLE) && q_valid;
  assign res_valid = (state == B_OUT);

  always_comb begin
    res.forward_x = sat16(68'(fwd.x));
    res.forward_y = sat16(68'(fwd.y));
    res.forward_z = sat16(68'(fwd.z));
    res.right_x   = rt.x[15:0];
    res.right_y   = rt.y[15:0];
    res.right_z   = rt.z[15:0];
    res.up_x      = upv.x[15:0];
    res.up_y      = upv.y[15:0];
    res.up_z      = upv.z[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            ang_p <= q_data.pitch;
            ang_y <= q_data.yaw;
            ai    <= 1'b0;
            state <= B_ANG;
          end
        end
        B_ANG: begin
          quad  <= a_quad;
          swap  <= a_swap;
          rr    <= a_rr;
          state <= B_XB;
        end
        B_XB: begin
          xa    <= 30'(prod);
          state <= B_XDIV;
        end
        B_XDIV: begin
          mh    <= mh_c;
          state <= B_XCOR;
        end
        B_XCOR: begin
          x     <= x_c;
          state <= B_XSQ;
        end
        B_XSQ: state <= B_X2;
        B_X2: begin
          x2    <= 30'((prod + Half) >>> 30);
          ts    <= Q30One;
          tc    <= Q30One;
          hk    <= 3'd7;
          hsin  <= 1'b1;
          state <= B_H1;
        end
        B_H1: state <= B_H2;
        B_H2: begin
          hn    <= n_c;
          state <= B_H3;
        end
        B_H3: begin
          hq0   <= 31'(prod >>> 31);
          state <= B_H4;
        end
        B_H4: begin
          if (hsin) begin
            ts    <= ht;
            hsin  <= 1'b0;
            state <= B_H1;
          end else begin
            tc   <= ht;
            hsin <= 1'b1;
            if (hk == 3'd1) begin
              state <= B_FS;
            end else begin
              hk    <= hk - 3'd1;
              state <= B_H1;
            end
          end
        end
        B_FS: state <= B_FS2;
        B_FS2: begin
          if (!ai) begin
            sp    <= sn;
            cp    <= cs;
            ai    <= 1'b1;
            state <= B_ANG;
          end else begin
            sy    <= sn;
            cy    <= cs;
            state <= B_F1;
          end
        end
        B_F1: state <= B_F2;
        B_F2: begin
          fwd.x <= 34'(rnd(prod, FwdShift));
          state <= B_F3;
        end
        B_F3: begin
          fwd.z    <= 34'(rnd(prod, FwdShift));
          fwd.y    <= 34'(rnd(68'(sp), FyShift));
          comp     <= 2'd0;
          cross_up <= 1'b0;
          state    <= B_CA;
        end
        B_CA: state <= B_CB;
        B_CB: begin
          acc   <= prod;
          state <= B_CC;
        end
        B_CC: begin
          case ({cross_up, comp})
            3'b000:  rt.x  <= 34'(cross_sat);
            3'b001:  rt.y  <= 34'(cross_sat);
            3'b010:  rt.z  <= 34'(cross_sat);
            3'b100:  upv.x <= 34'(cross_sat);
            3'b101:  upv.y <= 34'(cross_sat);
            default: upv.z <= 34'(cross_sat);
          endcase
          if (comp == 2'd2) begin
            comp <= 2'd0;
            if (!cross_up) begin
              cross_up <= 1'b1;
              state    <= B_CA;
            end else begin
              state <= B_OUT;
            end
          end else begin
            comp  <= comp + 2'd1;
            state <= B_CA;
          end
        end
        B_OUT: begin
          if (res_ready) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/yaw_pitch_camera_basis_top.sv =====
// top level of the yaw/pitch camera basis block with register port and output register
`timescale 1ns / 1ps

// Camera basis from mouse steps.
// Input channel: in_valid/in_stall carry pitch_step and yaw_step; a transfer
// happens when in_valid is high and in_stall is low. Output channel:
// out_valid/out_stall carry forward, right and up vectors, one result per input.
// Configuration: APB-style port, registers at byte addresses 0,4,..,20
// (sensitivity, invert_pitch, left_handed, world_up_x/y/z); pready is always high.
// Structure: the front end scales, clamps and wraps the angles for one input at
// a time; the back end works on one item at a time with its one shared 34x34
// multiplier, which steps through the sine and cosine series for both angles
// and then the two cross products. A two-entry queue sits between them and a
// result register follows the back end.
// Reset (rst, synchronous) restores the register defaults and zeroes both
// angles. While out_stall is high the result holds, the back end waits with
// its next result, and the queue and front end fill before in_stall stays high.

module yaw_pitch_camera_basis_top #(
  parameter int VECTOR_FRACTION_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [11:0] pitch_step,
  input  logic signed [11:0] yaw_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] forward_x,
  output logic signed [15:0] forward_y,
  output logic signed [15:0] forward_z,
  output logic signed [15:0] right_x,
  output logic signed [15:0] right_y,
  output logic signed [15:0] right_z,
  output logic signed [15:0] up_x,
  output logic signed [15:0] up_y,
  output logic signed [15:0] up_z
);
  import ypcb_pkg::*;

  localparam logic [2:0] REG_SENSITIVITY = 3'd0;
  localparam logic [2:0] REG_INVERT      = 3'd1;
  localparam logic [2:0] REG_LEFT        = 3'd2;
  localparam logic [2:0] REG_UP_X        = 3'd3;
  localparam logic [2:0] REG_UP_Y        = 3'd4;
  localparam logic [2:0] REG_UP_Z        = 3'd5;

  logic [11:0]        sensitivity;
  logic               invert_pitch;
  logic               left_handed;
  logic signed [15:0] world_up_x;
  logic signed [15:0] world_up_y;
  logic signed [15:0] world_up_z;
  logic               cfg_wr;

  front_cfg_t fcfg;
  basis_cfg_t bcfg;
  logic       q_push;
  angle_t     q_wdata;
  logic       q_full;
  logic       q_valid;
  angle_t     q_rdata;
  logic       q_pop;
  logic       res_valid;
  logic       res_ready;
  result_t    res;
  result_t    out_res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity  <= 12'd256;
      invert_pitch <= 1'b0;
      left_handed  <= 1'b0;
      world_up_x   <= 16'sd0;
      world_up_y   <= 16'sd16384;
      world_up_z   <= 16'sd0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_SENSITIVITY: sensitivity  <= pwdata[11:0];
        REG_INVERT:      invert_pitch <= pwdata[0];
        REG_LEFT:        left_handed  <= pwdata[0];
        REG_UP_X:        world_up_x   <= pwdata[15:0];
        REG_UP_Y:        world_up_y   <= pwdata[15:0];
        REG_UP_Z:        world_up_z   <= pwdata[15:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SENSITIVITY: prdata = 32'(sensitivity);
      REG_INVERT:      prdata = 32'(invert_pitch);
      REG_LEFT:        prdata = 32'(left_handed);
      REG_UP_X:        prdata = {16'd0, world_up_x};
      REG_UP_Y:        prdata = {16'd0, world_up_y};
      REG_UP_Z:        prdata = {16'd0, world_up_z};
      default:         prdata = 32'd0;
    endcase
  end

  assign fcfg = '{sensitivity: sensitivity, invert_pitch: invert_pitch};
  assign bcfg = '{left_handed: left_handed, world_up_x: world_up_x,
                  world_up_y: world_up_y, world_up_z: world_up_z};

  ypcb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (fcfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pitch_step (pitch_step),
    .yaw_step   (yaw_step),
    .push       (q_push),
    .push_data  (q_wdata),
    .q_full     (q_full)
  );

  ypcb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .valid     (q_valid),
    .pop_data  (q_rdata),
    .pop       (q_pop)
  );

  ypcb_back #(
    .VECTOR_FRACTION_BITS (VECTOR_FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (bcfg),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // result register
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
      out_res   <= res;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign forward_x = out_res.forward_x;
  assign forward_y = out_res.forward_y;
  assign forward_z = out_res.forward_z;
  assign right_x   = out_res.right_x;
  assign right_y   = out_res.right_y;
  assign right_z   = out_res.right_z;
  assign up_x      = out_res.up_x;
  assign up_y      = out_res.up_y;
  assign up_z      = out_res.up_z;

`ifndef ASSERT_OFF
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> out_valid)
    else $error("result transfer lost");

  a_front_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("front end took a second item while busy");
`endif

endmodule
